// ===== rtl/random_fade_led_pwm_core_assert.svh =====
// ----------------------------------------------------------------------------
// random_fade_led_pwm_core_assert
// assertion macros used by the checker file rfl_checker.sv
// ----------------------------------------------------------------------------
`ifndef RANDOM_FADE_LED_PWM_CORE_ASSERT_SVH
`define RANDOM_FADE_LED_PWM_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfl assertion failed");

// next-cycle implication, disabled while reset is low
`define RFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfl assertion failed");

`endif

// ===== rtl/rfl_pkg.sv =====
// ----------------------------------------------------------------------------
// rfl_pkg
// shared constants for the random fade led pwm core
// ----------------------------------------------------------------------------
package rfl_pkg;

	localparam int CHANNELS = 8;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LEVEL_W  = 8;
	localparam int MASK_W   = 8;
	localparam int CHAN_W   = 3;
	localparam int RAND_W   = 15;
	localparam int STEP_W   = $clog2(RAND_W);

	localparam logic [LEVEL_W-1:0] RESET_MAX_PAUSE      = LEVEL_W'(100);
	localparam logic [LEVEL_W-1:0] RESET_MAX_BRIGHTNESS = LEVEL_W'(250);

	// register indexes
	localparam logic REG_MAX_PAUSE      = 1'b0;
	localparam logic REG_MAX_BRIGHTNESS = 1'b1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

endpackage

// ===== rtl/rfl_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rfl_mod_unit
// bit-serial restoring remainder of a random word by an 8-bit modulus
// ----------------------------------------------------------------------------
module rfl_mod_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rfl_pkg::RAND_W-1:0]      dividend,
	input  logic [rfl_pkg::LEVEL_W-1:0]     divisor,
	output logic                            done,
	output logic [rfl_pkg::LEVEL_W-1:0]     remainder
);

	logic                          busy_q;
	logic                          done_q;
	logic [rfl_pkg::STEP_W-1:0]    cnt_q;
	logic [rfl_pkg::RAND_W-1:0]    word_q;
	logic [rfl_pkg::LEVEL_W-1:0]   div_q;
	logic [rfl_pkg::LEVEL_W-1:0]   rem_q;

	logic [rfl_pkg::LEVEL_W:0]     shifted;
	logic [rfl_pkg::LEVEL_W:0]     diff;
	logic [rfl_pkg::LEVEL_W-1:0]   rem_next;

	// one quotient bit per cycle
	always_comb begin
		shifted  = {rem_q, word_q[rfl_pkg::RAND_W-1]};
		diff     = shifted - {1'b0, div_q};
		rem_next = (shifted >= {1'b0, div_q}) ? diff[rfl_pkg::LEVEL_W-1:0]
		                                      : shifted[rfl_pkg::LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rfl_pkg::STEP_W'(rfl_pkg::RAND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			word_q <= word_q << 1;
			rem_q  <= rem_next;
		end
	end

	// zero modulus draws zero
	assign done      = done_q;
	assign remainder = (div_q == '0) ? '0 : rem_q;

endmodule

// ===== rtl/random_fade_led_pwm_core.sv =====
// ----------------------------------------------------------------------------
// random_fade_led_pwm_core
// multi-channel led fader with random pauses and targets plus a pwm mask
// ----------------------------------------------------------------------------
// usage:
//   request channel: req_valid/req_stall carry kind, channel, random_pause and
//   random_target. kind 0 steps the fade of one channel, kind 1 is a pwm tick.
//   result channel: res_valid/res_stall carry led_mask, level_now, in_pause,
//   exactly one result per request, in order.
//   apb port: max_pause at 0x0, max_brightness at 0x4, written while idle.
// timing:
//   a plain fade step passes through S_FADE and S_DONE into the output register;
//   a step that ends a fade cycle runs the serial modulo unit twice, in S_DRAW_P
//   and S_DRAW_T. a pwm tick sweeps the channels in S_PWM, one compare each. one
//   request is in flight at a time, req_stall is high while it is worked on.
// reset:
//   levels, targets, pauses and the pwm counter clear, max_pause = 100,
//   max_brightness = 250, no result pending.
// stall:
//   a held result waits in the output register; the finished next result
//   waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module random_fade_led_pwm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic [rfl_pkg::CHAN_W-1:0]          channel,
	input  logic [rfl_pkg::RAND_W-1:0]          random_pause,
	input  logic [rfl_pkg::RAND_W-1:0]          random_target,
	// result channel
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [rfl_pkg::MASK_W-1:0]          led_mask,
	output logic [rfl_pkg::LEVEL_W-1:0]         level_now,
	output logic                                in_pause,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rfl_pkg::PADDR_W-1:0]         paddr,
	input  logic [rfl_pkg::PDATA_W-1:0]         pwdata,
	output logic [rfl_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FADE   = 3'd1;
	localparam logic [2:0] S_DRAW_P = 3'd2;
	localparam logic [2:0] S_DRAW_T = 3'd3;
	localparam logic [2:0] S_PWM    = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	localparam int LW = rfl_pkg::LEVEL_W;

	logic [2:0]                   state_q;

	// configuration registers
	logic [LW-1:0]                max_pause_q;
	logic [LW-1:0]                max_bright_q;
	logic                         cfg_wr;

	// per-channel state
	logic [LW-1:0]                cur_q   [rfl_pkg::CHANNELS];
	logic [LW-1:0]                tgt_q   [rfl_pkg::CHANNELS];
	logic [LW-1:0]                pause_q [rfl_pkg::CHANNELS];
	logic [LW-1:0]                pwm_cnt_q;

	// captured request
	logic [rfl_pkg::IDX_W-1:0]    idx_q;
	logic [rfl_pkg::RAND_W-1:0]   rp_q;
	logic [rfl_pkg::RAND_W-1:0]   rt_q;

	// finished result waiting for the output register
	logic [rfl_pkg::MASK_W-1:0]   mask_q;
	logic [LW-1:0]                lvl_q;
	logic                         paused_q;

	// output register
	logic                         res_valid_q;
	logic [rfl_pkg::MASK_W-1:0]   led_mask_q;
	logic [LW-1:0]                level_now_q;
	logic                         in_pause_q;

	logic                         req_acc;
	logic                         out_free;
	logic                         chan_ok;

	// fade arithmetic on the addressed channel
	logic [LW-1:0]                p_rd;
	logic [LW-1:0]                c_rd;
	logic [LW-1:0]                t_rd;
	logic [LW-1:0]                c_up;
	logic [LW-1:0]                t_new;
	logic [LW-1:0]                c_new;
	logic                         need_draw;

	// shared modulo unit
	logic                         mod_start;
	logic [rfl_pkg::RAND_W-1:0]   mod_word;
	logic [LW-1:0]                mod_div;
	logic                         mod_done;
	logic [LW-1:0]                mod_rem;

	logic                         pwm_hit;
	logic                         pwm_last;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign chan_ok   = (32'(channel) < rfl_pkg::CHANNELS);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			rfl_pkg::REG_MAX_PAUSE:      prdata = rfl_pkg::PDATA_W'(max_pause_q);
			rfl_pkg::REG_MAX_BRIGHTNESS: prdata = rfl_pkg::PDATA_W'(max_bright_q);
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pause_q  <= rfl_pkg::RESET_MAX_PAUSE;
			max_bright_q <= rfl_pkg::RESET_MAX_BRIGHTNESS;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rfl_pkg::REG_MAX_PAUSE:      max_pause_q  <= pwdata[LW-1:0];
				rfl_pkg::REG_MAX_BRIGHTNESS: max_bright_q <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- fade step ----------------
	always_comb begin
		p_rd  = pause_q[idx_q];
		c_rd  = cur_q[idx_q];
		t_rd  = tgt_q[idx_q];
		// climb toward the target
		c_up  = (c_rd < t_rd) ? c_rd + 1'b1 : c_rd;
		// target reached: head back down in the same step
		t_new = (c_up == t_rd) ? '0 : t_rd;
		c_new = (c_up > t_new) ? c_up - 1'b1 : c_up;
		need_draw = (c_new == '0) && (t_new == '0);
	end

	// ---------------- pwm sweep: one compare per cycle ----------------
	assign pwm_hit  = (pwm_cnt_q < cur_q[idx_q]);
	assign pwm_last = (idx_q == rfl_pkg::IDX_W'(rfl_pkg::CHANNELS - 1));

	// ---------------- modulo unit control ----------------
	always_comb begin
		mod_start = 1'b0;
		mod_word  = rp_q;
		mod_div   = max_pause_q;
		if (state_q == S_FADE && p_rd == '0 && need_draw) begin
			mod_start = 1'b1;
		end else if (state_q == S_DRAW_P && mod_done) begin
			// pause drawn, now the target
			mod_start = 1'b1;
			mod_word  = rt_q;
			mod_div   = max_bright_q;
		end
	end

	rfl_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_word),
		.divisor   (mod_div),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// ---------------- sequencer and channel state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pwm_cnt_q <= '0;
			for (int i = 0; i < rfl_pkg::CHANNELS; i++) begin
				cur_q[i]   <= '0;
				tgt_q[i]   <= '0;
				pause_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (kind) begin
							state_q <= S_PWM;
						end else if (chan_ok) begin
							state_q <= S_FADE;
						end else begin
							// channel outside the array: zero result
							state_q <= S_DONE;
						end
					end
				end
				S_FADE: begin
					if (p_rd != '0) begin
						pause_q[idx_q] <= p_rd - 1'b1;
						state_q        <= S_DONE;
					end else begin
						cur_q[idx_q] <= c_new;
						tgt_q[idx_q] <= t_new;
						state_q      <= need_draw ? S_DRAW_P : S_DONE;
					end
				end
				S_DRAW_P: begin
					if (mod_done) begin
						pause_q[idx_q] <= mod_rem;
						state_q        <= S_DRAW_T;
					end
				end
				S_DRAW_T: begin
					if (mod_done) begin
						tgt_q[idx_q] <= mod_rem;
						state_q      <= S_DONE;
					end
				end
				S_PWM: begin
					if (pwm_last) begin
						pwm_cnt_q <= pwm_cnt_q + 1'b1;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result assembly
	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx_q    <= kind ? '0 : rfl_pkg::IDX_W'(channel);
			rp_q     <= random_pause;
			rt_q     <= random_target;
			mask_q   <= '0;
			lvl_q    <= '0;
			paused_q <= 1'b0;
		end else begin
			case (state_q)
				S_FADE: begin
					if (p_rd != '0) begin
						lvl_q    <= c_rd;
						paused_q <= (p_rd != LW'(1));
					end else begin
						lvl_q    <= c_new;
						paused_q <= 1'b0;
					end
				end
				S_DRAW_P: begin
					if (mod_done) begin
						paused_q <= (mod_rem != '0);
					end
				end
				S_PWM: begin
					// channels past the mask width have no bit
					if (32'(idx_q) < rfl_pkg::MASK_W) begin
						mask_q[3'(idx_q)] <= pwm_hit;
					end
					if (!pwm_last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			led_mask_q  <= mask_q;
			level_now_q <= lvl_q;
			in_pause_q  <= paused_q;
		end
	end

	assign res_valid = res_valid_q;
	assign led_mask  = led_mask_q;
	assign level_now = level_now_q;
	assign in_pause  = in_pause_q;

endmodule

// ===== rtl/rfl_checker.sv =====
// ----------------------------------------------------------------------------
// rfl_checker
// port-level checks for random_fade_led_pwm_core, bound to the top level
// ----------------------------------------------------------------------------
`include "random_fade_led_pwm_core_assert.svh"

module rfl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_stall,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic [rfl_pkg::MASK_W-1:0]      led_mask,
	input logic [rfl_pkg::LEVEL_W-1:0]     level_now,
	input logic                            in_pause
);

	// one request in flight: busy right after an accept
	`RFL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall)

	// a held result stays put
	`RFL_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(led_mask) && $stable(level_now) && $stable(in_pause))

	// a lit mask only comes from a tick, which reports no fade fields
	`RFL_ASSERT_NOW(a_tick_fields, clk, arst_n, res_valid && (led_mask != '0), (level_now == '0) && !in_pause)

	// a channel in its pause sits dark
	`RFL_ASSERT_NOW(a_pause_dark, clk, arst_n, res_valid && in_pause, level_now == '0)

endmodule

bind random_fade_led_pwm_core rfl_checker u_rfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.led_mask  (led_mask),
	.level_now (level_now),
	.in_pause  (in_pause)
);
